// ===== src/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ARPC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Checked at every edge, reset included.
`define ARPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`endif

// ===== src/arpc_pkg.sv =====
`default_nettype none
package arpc_pkg;

	localparam int MAC_W = 48;
	localparam int IP_W  = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 48;
	localparam logic [CFG_IDX_W-1:0] REG_OUR_MAC = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OUR_IP  = 1'd1;

	localparam logic [1:0] FUNC_PACKET   = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP   = 2'd1;
	localparam logic [1:0] FUNC_DISCOVER = 2'd2;

	localparam logic [15:0] HW_ETHERNET  = 16'h0001;
	localparam logic [15:0] PROTO_IPV4   = 16'h0800;
	localparam logic [7:0]  HW_LEN_ETH   = 8'd6;
	localparam logic [7:0]  PROTO_LEN_IP = 8'd4;
	localparam logic [15:0] OPER_REQUEST = 16'd1;
	localparam logic [15:0] OPER_REPLY   = 16'd2;

	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_REPLY    = 2'd1;
	localparam logic [1:0] KIND_REQUEST  = 2'd2;
	localparam logic [1:0] KIND_LOOKUP   = 2'd3;

	localparam logic [1:0] EMIT_OP_NONE    = 2'd0;
	localparam logic [1:0] EMIT_OP_REQUEST = 2'd1;
	localparam logic [1:0] EMIT_OP_REPLY   = 2'd2;

	localparam logic [MAC_W-1:0] MAC_BROADCAST = {MAC_W{1'b1}};

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_REPLY,
		CMD_DISCOVER,
		CMD_LOOKUP,
		CMD_STORE
	} cmd_kind_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_SCAN,
		B_FINISH
	} back_state_t;

	typedef struct packed {
		logic [MAC_W-1:0] mac;
		logic [IP_W-1:0]  ip;
	} cfg_t;

	// reply: mac/ip = sender, discover and lookup: ip = target, store: sender pair
	typedef struct packed {
		cmd_kind_t        kind;
		logic [MAC_W-1:0] mac;
		logic [IP_W-1:0]  ip;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [MAC_W-1:0] dest_mac;
		logic [1:0]       out_operation;
		logic [MAC_W-1:0] out_sender_mac;
		logic [IP_W-1:0]  out_sender_ip;
		logic [MAC_W-1:0] out_target_mac;
		logic [IP_W-1:0]  out_target_ip;
		logic             hit;
		logic [MAC_W-1:0] found_mac;
	} rsp_t;

endpackage
`default_nettype wire

// ===== src/arpc_in_if.sv =====
`default_nettype none
interface arpc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] hw_type;
	logic [15:0] proto_type;
	logic [7:0]  hw_len;
	logic [7:0]  proto_len;
	logic [15:0] arp_operation_in;
	logic [47:0] sender_mac;
	logic [31:0] src_ip;
	logic [31:0] addr_ip;

	modport source (
		output valid, func, hw_type, proto_type, hw_len, proto_len,
			arp_operation_in, sender_mac, src_ip, addr_ip,
		input  ready
	);
	modport sink (
		input  valid, func, hw_type, proto_type, hw_len, proto_len,
			arp_operation_in, sender_mac, src_ip, addr_ip,
		output ready
	);
endinterface
`default_nettype wire

// ===== src/arpc_out_if.sv =====
`default_nettype none
interface arpc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic [47:0] dest_mac;
	logic [1:0]  out_operation;
	logic [47:0] out_sender_mac;
	logic [31:0] out_sender_ip;
	logic [47:0] out_target_mac;
	logic [31:0] out_target_ip;
	logic        hit;
	logic [47:0] found_mac;

	modport source (
		output valid, result_kind, dest_mac, out_operation, out_sender_mac,
			out_sender_ip, out_target_mac, out_target_ip, hit, found_mac,
		input  ready
	);
	modport sink (
		input  valid, result_kind, dest_mac, out_operation, out_sender_mac,
			out_sender_ip, out_target_mac, out_target_ip, hit, found_mac,
		output ready
	);
endinterface
`default_nettype wire

// ===== src/arp_responder_and_cache_unit.sv =====
// ARP responder with an IPv4-to-MAC cache. Every accepted beat on req gives exactly one
// beat on rsp, in order; packets that need no answer give result kind "nothing". The
// front end classifies each beat and drops it into a two-entry command queue, so req
// keeps accepting while the queue has room, also while the back end works and while a
// result waits in the output register. Lookups and received replies walk the cache
// through its single registered read port, one entry per cycle, stopping at the first
// match. The back end takes one item at a time. Valid bits live in flip-flops, so the
// cache is usable right after reset with no clearing pass. When the cache is full a new
// address replaces entries in round-robin order. Write our_mac and our_ip only while no
// item is in flight.
`default_nettype none
module arp_responder_and_cache_unit import arpc_pkg::*; #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	arpc_in_if.sink               req,
	arpc_out_if.source            rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	logic push_valid;
	logic push_ready;
	cmd_t push_data;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OUR_MAC: cfg_q.mac <= cfg_data[MAC_W-1:0];
				REG_OUR_IP:  cfg_q.ip  <= cfg_data[IP_W-1:0];
				default: ;
			endcase
		end
	end

	arpc_front u_front (
		.req        (req),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	arpc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	arpc_back #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.cfg       (cfg_q),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ===== src/arpc_front.sv =====
`default_nettype none
module arpc_front import arpc_pkg::*; (
	arpc_in_if.sink    req,
	input  cfg_t       cfg,
	output logic       push_valid,
	input  logic       push_ready,
	output cmd_t       push_data
);

	logic hdr_ok;

	assign req.ready  = push_ready;
	assign push_valid = req.valid;

	assign hdr_ok = (req.hw_type == HW_ETHERNET) && (req.proto_type == PROTO_IPV4) &&
		(req.hw_len == HW_LEN_ETH) && (req.proto_len == PROTO_LEN_IP);

	always_comb begin
		push_data.kind = CMD_NONE;
		push_data.mac  = req.sender_mac;
		push_data.ip   = req.src_ip;
		unique case (req.func)
			FUNC_PACKET: begin
				if (hdr_ok) begin
					priority if (req.arp_operation_in == OPER_REQUEST &&
						req.addr_ip == cfg.ip) begin
						push_data.kind = CMD_REPLY;
					end else if (req.arp_operation_in == OPER_REPLY) begin
						push_data.kind = CMD_STORE;
					end else begin
						push_data.kind = CMD_NONE;
					end
				end
			end
			FUNC_LOOKUP: begin
				push_data.kind = CMD_LOOKUP;
				push_data.ip   = req.addr_ip;
			end
			FUNC_DISCOVER: begin
				push_data.kind = CMD_DISCOVER;
				push_data.ip   = req.addr_ip;
			end
			default: begin
				push_data.kind = CMD_NONE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== src/arpc_queue.sv =====
`default_nettype none
module arpc_queue import arpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_data,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_data
);

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)      count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== src/arpc_back.sv =====
`default_nettype none
module arpc_back import arpc_pkg::*; #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  cmd_t        pop_data,
	input  cfg_t        cfg,
	arpc_out_if.source  rsp
);

	localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(CACHE_ENTRIES - 1);

	back_state_t state_q;
	back_state_t state_d;

	cmd_t                 cmd_q;
	logic [IP_W-1:0]      ip_mem  [CACHE_ENTRIES];
	logic [MAC_W-1:0]     mac_mem [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;
	logic [IW-1:0]        rp_q;

	logic [IW-1:0]        idx_q;
	logic                 issued_all_q;
	logic                 rd_valid_s1;
	logic [IW-1:0]        rd_idx_s1;
	logic [IP_W-1:0]      rd_ip_s1;
	logic [MAC_W-1:0]     rd_mac_s1;

	logic                 found_q;
	logic [IW-1:0]        found_idx_q;
	logic [MAC_W-1:0]     found_mac_q;
	logic                 free_found_q;
	logic [IW-1:0]        free_idx_q;

	logic                 rsp_valid_q;
	rsp_t                 rsp_q;
	rsp_t                 res;

	logic                 out_free;
	logic                 take;
	logic                 issue;
	logic                 finish;
	logic                 compare;
	logic                 match_s1;
	logic                 scan_end;
	logic                 wr_en;
	logic [IW-1:0]        slot;

	assign out_free = !rsp_valid_q || rsp.ready;
	assign compare  = (state_q == B_SCAN) && rd_valid_s1;
	assign match_s1 = compare && valid_q[rd_idx_s1] && (rd_ip_s1 == cmd_q.ip);
	assign scan_end = compare && (match_s1 || rd_idx_s1 == LAST);
	assign take     = pop_valid && pop_ready;

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		issue     = 1'b0;
		finish    = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = (pop_data.kind == CMD_LOOKUP || pop_data.kind == CMD_STORE) ?
						B_SCAN : B_FINISH;
				end
			end
			B_SCAN: begin
				issue = !issued_all_q && !scan_end;
				if (scan_end) state_d = B_FINISH;
			end
			B_FINISH: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= B_IDLE;
		else         state_q <= state_d;
	end

	assign slot  = found_q ? found_idx_q : (free_found_q ? free_idx_q : rp_q);
	assign wr_en = finish && (cmd_q.kind == CMD_STORE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			rp_q         <= '0;
			idx_q        <= '0;
			issued_all_q <= 1'b0;
			rd_valid_s1  <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			rd_valid_s1 <= issue;
			if (take) begin
				idx_q        <= '0;
				issued_all_q <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
			if (issue) begin
				idx_q        <= idx_q + IW'(1);
				issued_all_q <= (idx_q == LAST);
			end
			if (match_s1) found_q <= 1'b1;
			if (compare && !valid_q[rd_idx_s1]) free_found_q <= 1'b1;
			if (wr_en) begin
				valid_q[slot] <= 1'b1;
				if (!found_q && !free_found_q) begin
					rp_q <= (rp_q == LAST) ? '0 : rp_q + IW'(1);
				end
			end
			if (finish)         rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)  cmd_q     <= pop_data;
		if (issue) rd_idx_s1 <= idx_q;
		if (match_s1) begin
			found_idx_q <= rd_idx_s1;
			found_mac_q <= rd_mac_s1;
		end
		if (compare && !valid_q[rd_idx_s1] && !free_found_q) free_idx_q <= rd_idx_s1;
		if (finish) rsp_q <= res;
	end

	// cache memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ip_mem[slot]  <= cmd_q.ip;
			mac_mem[slot] <= cmd_q.mac;
		end
		rd_ip_s1  <= ip_mem[idx_q];
		rd_mac_s1 <= mac_mem[idx_q];
	end

	always_comb begin
		res = '0;
		unique case (cmd_q.kind)
			CMD_REPLY: begin
				res.result_kind    = KIND_REPLY;
				res.dest_mac       = cmd_q.mac;
				res.out_operation  = EMIT_OP_REPLY;
				res.out_sender_mac = cfg.mac;
				res.out_sender_ip  = cfg.ip;
				res.out_target_mac = cmd_q.mac;
				res.out_target_ip  = cmd_q.ip;
			end
			CMD_DISCOVER: begin
				res.result_kind    = KIND_REQUEST;
				res.dest_mac       = MAC_BROADCAST;
				res.out_operation  = EMIT_OP_REQUEST;
				res.out_sender_mac = cfg.mac;
				res.out_sender_ip  = cfg.ip;
				res.out_target_ip  = cmd_q.ip;
			end
			CMD_LOOKUP: begin
				res.result_kind = KIND_LOOKUP;
				res.hit         = found_q;
				res.found_mac   = found_q ? found_mac_q : '0;
			end
			default: begin
				res.result_kind = KIND_NONE;
			end
		endcase
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.result_kind    = rsp_q.result_kind;
	assign rsp.dest_mac       = rsp_q.dest_mac;
	assign rsp.out_operation  = rsp_q.out_operation;
	assign rsp.out_sender_mac = rsp_q.out_sender_mac;
	assign rsp.out_sender_ip  = rsp_q.out_sender_ip;
	assign rsp.out_target_mac = rsp_q.out_target_mac;
	assign rsp.out_target_ip  = rsp_q.out_target_ip;
	assign rsp.hit            = rsp_q.hit;
	assign rsp.found_mac      = rsp_q.found_mac;

endmodule
`default_nettype wire

// ===== src/arpc_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module arpc_checker import arpc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  result_kind,
	input logic [47:0] dest_mac,
	input logic [1:0]  out_operation,
	input logic [47:0] out_sender_mac,
	input logic [31:0] out_sender_ip,
	input logic [47:0] out_target_mac,
	input logic [31:0] out_target_ip,
	input logic        hit,
	input logic [47:0] found_mac
);

	`ARPC_ASSERT_ALWAYS(a_no_beat_in_reset, clk, !arst_n |-> !rsp_valid, "rsp valid in reset")
	`ARPC_ASSERT(a_valid_holds, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
	`ARPC_ASSERT(a_payload_holds, clk, arst_n, rsp_valid && !rsp_ready |=> $stable({result_kind, dest_mac, out_operation, found_mac, hit}), "rsp payload moved")
	`ARPC_ASSERT(a_none_is_zero, clk, arst_n, rsp_valid && result_kind == KIND_NONE |-> dest_mac == '0 && out_operation == EMIT_OP_NONE && out_sender_mac == '0 && out_sender_ip == '0 && out_target_mac == '0 && out_target_ip == '0 && !hit && found_mac == '0, "empty result carries data")
	`ARPC_ASSERT(a_hit_only_lookup, clk, arst_n, rsp_valid && (hit || found_mac != '0) |-> result_kind == KIND_LOOKUP && hit, "hit data outside a lookup hit")

endmodule

bind arp_responder_and_cache_unit arpc_checker u_arpc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.result_kind    (rsp.result_kind),
	.dest_mac       (rsp.dest_mac),
	.out_operation  (rsp.out_operation),
	.out_sender_mac (rsp.out_sender_mac),
	.out_sender_ip  (rsp.out_sender_ip),
	.out_target_mac (rsp.out_target_mac),
	.out_target_ip  (rsp.out_target_ip),
	.hit            (rsp.hit),
	.found_mac      (rsp.found_mac)
);
`default_nettype wire
